// ===== rtl/bmpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the BMP pixel decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int unsigned DimW         = 13;
  localparam int unsigned IndexW       = 24;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned MaxDimDef    = 4096;
  localparam int unsigned PalEntriesDef = 256;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd2;

  // pixel modes
  localparam logic [1:0] MODE_PAL8   = 2'd0;
  localparam logic [1:0] MODE_RGB555 = 2'd1;
  localparam logic [1:0] MODE_RGB24  = 2'd2;
  localparam logic [1:0] MODE_RGBA32 = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]        mode;
    logic [31:0]       pix;
    logic [IndexW-1:0] index;
    logic              last;
  } pix_item_t;

endpackage
`default_nettype wire

// ===== rtl/bmp_pixel_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pixel_decoder
// Uncompressed BMP pixel-data decoder, one byte per request, RGBA out.
//
// Input channel (in_valid_i/in_ready_o, data_byte_i) takes the pixel-data
// bytes in file order; in 8-bit palette mode the first 1024 bytes load the
// BGRA palette RAM. Output channel (out_valid_o/out_ready_i) returns one RGBA
// pixel with its top-down frame index per completed pixel; row padding bytes
// produce nothing. The config channel writes width, height and mode and
// restarts the image position; the palette is kept.
// One byte is taken every cycle while in_ready_o is high. A pixel passes
// through the palette RAM read stage, then the output register.
// While the receiver stalls, the read stage and the output register hold one
// pixel each, and in_ready_o drops once both are full.
// Reset clears all position, fill and handshake state; palette contents are
// undefined until loaded. Width and height reset to 1, mode to 24-bit.
// ----------------------------------------------------------------------------
module bmp_pixel_decoder
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION   = MaxDimDef,
  parameter int unsigned PALETTE_ENTRIES = PalEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [7:0]              alpha_o,
  output logic [IndexW-1:0]       pixel_index_o,
  output logic                    last_pixel_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic            accept;
  logic            pal_we, pal_re;
  logic [3:0]      pal_be;
  logic [AW-1:0]   pal_addr;
  logic [31:0]     pal_wdata, pal_rdata;
  logic            item_valid;
  pix_item_t       item;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  bmpd_ctrl #(
    .MAX_DIMENSION   (MAX_DIMENSION),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .pal_we_o     (pal_we),
    .pal_be_o     (pal_be),
    .pal_addr_o   (pal_addr),
    .pal_wdata_o  (pal_wdata),
    .pal_re_o     (pal_re),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bmpd_palette_mem #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .be_i    (pal_be),
    .addr_i  (pal_addr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .rdata_o (pal_rdata)
  );

  bmpd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .pal_rdata_i   (pal_rdata),
    .ready_o       (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .pixel_index_o (pixel_index_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
`default_nettype wire

// ===== rtl/bmpd_palette_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_palette_mem
// Single-port palette RAM, BGRA words with byte-lane write, registered read.
// ----------------------------------------------------------------------------
module bmpd_palette_mem #(
  parameter int unsigned ENTRIES = 256,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [3:0]    be_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic          re_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem_q [ENTRIES];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int k = 0; k < 4; k++) begin
        if (be_i[k]) begin
          mem_q[addr_i][k*8 +: 8] <= wdata_i[k*8 +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/bmpd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_ctrl
// Configuration registers, palette fill, byte assembly, row/column tracking
// and frame index generation.
// ----------------------------------------------------------------------------
module bmpd_ctrl
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION   = MaxDimDef,
  parameter int unsigned PALETTE_ENTRIES = PalEntriesDef,
  localparam int unsigned AW  = $clog2(PALETTE_ENTRIES),
  localparam int unsigned FCW = AW + 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    pal_we_o,
  output logic [3:0]              pal_be_o,
  output logic [AW-1:0]           pal_addr_o,
  output logic [31:0]             pal_wdata_o,
  output logic                    pal_re_o,
  output logic                    item_valid_o,
  output pix_item_t               item_o
);

  localparam logic [FCW-1:0] FillLast = FCW'(4 * PALETTE_ENTRIES - 1);

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      r = DimW'(MAX_DIMENSION);
    end
    return r;
  endfunction

  logic [DimW-1:0]   width_q, width_d, height_q, height_d;
  logic [1:0]        mode_q, mode_d;
  logic [IndexW-1:0] frame_base_q, frame_base_d;
  logic [IndexW-1:0] row_base_q, row_base_d;
  logic [DimW-1:0]   col_q, col_d, row_q, row_d;
  logic [1:0]        pad_q, pad_d;
  logic [1:0]        bip_q, bip_d;
  logic [23:0]       partial_q, partial_d;
  logic [FCW-1:0]    fill_q, fill_d;
  logic              loaded_q, loaded_d;

  logic              cfg_hit;
  logic [1:0]        row_bytes_lo;
  logic [31:0]       pix;

  always_comb begin
    width_d      = width_q;
    height_d     = height_q;
    mode_d       = mode_q;
    frame_base_d = frame_base_q;
    row_base_d   = row_base_q;
    col_d        = col_q;
    row_d        = row_q;
    pad_d        = pad_q;
    bip_d        = bip_q;
    partial_d    = partial_q;
    fill_d       = fill_q;
    loaded_d     = loaded_q;
    pal_we_o     = 1'b0;
    pal_be_o     = '0;
    pal_addr_o   = data_byte_i[AW-1:0];
    pal_wdata_o  = {4{data_byte_i}};
    pal_re_o     = 1'b0;
    item_valid_o = 1'b0;
    cfg_hit      = 1'b0;

    row_bytes_lo = 2'(width_q[1:0] * (mode_q + 2'd1));
    pix = {8'd0, partial_q} | (32'(data_byte_i) << {mode_q, 3'b000});

    item_o.mode  = mode_q;
    item_o.pix   = pix;
    item_o.index = row_base_q + IndexW'(col_q);
    item_o.last  = (col_q == width_q - DimW'(1)) && (row_q == height_q - DimW'(1));

    if (accept_i) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else if (mode_q == MODE_PAL8 && !loaded_q) begin
        pal_we_o   = 1'b1;
        pal_addr_o = fill_q[FCW-1:2];
        pal_be_o   = 4'b0001 << fill_q[1:0];
        if (fill_q == FillLast) begin
          loaded_d = 1'b1;
          fill_d   = '0;
        end else begin
          fill_d = fill_q + FCW'(1);
        end
      end else if (bip_q < mode_q) begin
        partial_d = partial_q | (24'(data_byte_i) << {bip_q, 3'b000});
        bip_d     = bip_q + 2'd1;
      end else begin
        item_valid_o = 1'b1;
        pal_re_o     = (mode_q == MODE_PAL8);
        bip_d        = 2'd0;
        partial_d    = '0;
        if (col_q == width_q - DimW'(1)) begin
          col_d = '0;
          pad_d = 2'd0 - row_bytes_lo;
          if (row_q == height_q - DimW'(1)) begin
            row_d      = '0;
            row_base_d = frame_base_q;
          end else begin
            row_d      = row_q + DimW'(1);
            row_base_d = row_base_q - IndexW'(width_q);
          end
        end else begin
          col_d = col_q + DimW'(1);
        end
      end
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH: begin
          width_d = eff_dim(cfg_data_i);
          cfg_hit = 1'b1;
        end
        CFG_HEIGHT: begin
          height_d = eff_dim(cfg_data_i);
          cfg_hit  = 1'b1;
        end
        CFG_MODE: begin
          mode_d  = cfg_data_i[1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
      if (cfg_hit) begin
        frame_base_d = IndexW'((height_d - DimW'(1)) * width_d);
        row_base_d   = frame_base_d;
        col_d        = '0;
        row_d        = '0;
        pad_d        = 2'd0;
        bip_d        = 2'd0;
        partial_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= DimW'(1);
      height_q     <= DimW'(1);
      mode_q       <= MODE_RGB24;
      frame_base_q <= '0;
      row_base_q   <= '0;
      col_q        <= '0;
      row_q        <= '0;
      pad_q        <= 2'd0;
      bip_q        <= 2'd0;
      partial_q    <= '0;
      fill_q       <= '0;
      loaded_q     <= 1'b0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      mode_q       <= mode_d;
      frame_base_q <= frame_base_d;
      row_base_q   <= row_base_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pad_q        <= pad_d;
      bip_q        <= bip_d;
      partial_q    <= partial_d;
      fill_q       <= fill_d;
      loaded_q     <= loaded_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bmpd_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_out
// Palette read stage, color decode and output register with backpressure.
// ----------------------------------------------------------------------------
module bmpd_out
  import bmpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire pix_item_t          item_i,
  input  wire logic [31:0]        pal_rdata_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [7:0]              alpha_o,
  output logic [IndexW-1:0]       pixel_index_o,
  output logic                    last_pixel_o
);

  logic      s1_valid_q, s1_valid_d;
  pix_item_t s1_q;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic [7:0] r, g, b, a;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic [IndexW-1:0] index_q;
  logic      last_q;

  assign advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (item_valid_i) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    case (s1_q.mode)
      MODE_PAL8: begin
        b = pal_rdata_i[7:0];
        g = pal_rdata_i[15:8];
        r = pal_rdata_i[23:16];
        a = pal_rdata_i[31:24];
      end
      MODE_RGB555: begin
        b = {s1_q.pix[4:0], 3'b000};
        g = {s1_q.pix[9:5], 3'b000};
        r = {s1_q.pix[14:10], 3'b000};
        a = ALPHA_OPAQUE;
      end
      MODE_RGB24: begin
        b = s1_q.pix[7:0];
        g = s1_q.pix[15:8];
        r = s1_q.pix[23:16];
        a = ALPHA_OPAQUE;
      end
      default: begin
        b = s1_q.pix[7:0];
        g = s1_q.pix[15:8];
        r = s1_q.pix[23:16];
        a = s1_q.pix[31:24];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_q <= item_i;
    end
    if (advance) begin
      red_q   <= r;
      green_q <= g;
      blue_q  <= b;
      alpha_q <= a;
      index_q <= s1_q.index;
      last_q  <= s1_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign alpha_o       = alpha_q;
  assign pixel_index_o = index_q;
  assign last_pixel_o  = last_q;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bmp_pixel_decoder. Byte, pixel and register
// requests all use valid/ready. Each accepted byte is decoded by a local
// model of the decoder: palette fill, partial pixels, row padding and the
// bottom-up index. The model queues the pixel it predicts, and a monitor
// compares every returned pixel against that queue. Directed tests cover
// reset state, every pixel mode, dimension clamping, register restart,
// palette loading and backpressure. A long randomized run follows, with
// random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import bmpd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_BYTES  = 250;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [IndexW-1:0] index;
    logic              is_last;
  } pixel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DimW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic [7:0]         alpha_o;
  logic [IndexW-1:0]  pixel_index_o;
  logic               last_pixel_o;

  bmp_pixel_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .pixel_index_o (pixel_index_o),
    .last_pixel_o  (last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder model state
  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic [1:0]        mode_q;
  logic [31:0]       palette_q [PalEntriesDef];
  logic [9:0]        fill_q;
  bit                loaded_q;
  int unsigned       byte_pos_q;
  logic [23:0]       partial_q;
  int unsigned       col_q;
  int unsigned       row_q;
  int unsigned       pad_q;
  logic [IndexW-1:0] base_q;

  pixel_t expected_pixels[$];
  int     errors  = 0;
  bit     no_idle = 1'b0;
  int     rx_hold = 0;

  function automatic int unsigned eff_dim(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDimDef) return MaxDimDef;
    return v;
  endfunction

  function automatic void restart_image();
    byte_pos_q = 0;
    partial_q  = '0;
    col_q      = 0;
    row_q      = 0;
    pad_q      = 0;
    base_q     = IndexW'((eff_dim(height_q) - 1) * eff_dim(width_q));
  endfunction

  function automatic void apply_cfg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
    case (idx)
      CFG_WIDTH:  width_q = data;
      CFG_HEIGHT: height_q = data;
      CFG_MODE:   mode_q = data[1:0];
      default:    return;
    endcase
    restart_image();
  endfunction

  function automatic void decode_byte(logic [7:0] value);
    int unsigned w;
    int unsigned h;
    int unsigned bpp;
    logic [31:0] pix;
    logic [31:0] entry;
    pixel_t      px;
    w   = eff_dim(width_q);
    h   = eff_dim(height_q);
    bpp = int'(mode_q) + 1;
    if (pad_q != 0) begin
      pad_q--;
      return;
    end
    if (mode_q == MODE_PAL8 && !loaded_q) begin
      palette_q[fill_q[9:2]][fill_q[1:0]*8 +: 8] = value;
      if (fill_q == 10'd1023) begin
        loaded_q = 1'b1;
        fill_q   = '0;
      end else begin
        fill_q++;
      end
      return;
    end
    if (byte_pos_q + 1 < bpp) begin
      partial_q = partial_q | (24'(value) << (byte_pos_q * 8));
      byte_pos_q++;
      return;
    end
    pix = {8'h00, partial_q} | (32'(value) << ((bpp - 1) * 8));
    case (mode_q)
      MODE_PAL8: begin
        entry    = palette_q[value];
        px.blue  = entry[7:0];
        px.green = entry[15:8];
        px.red   = entry[23:16];
        px.alpha = entry[31:24];
      end
      MODE_RGB555: begin
        px.blue  = {pix[4:0], 3'b000};
        px.green = {pix[9:5], 3'b000};
        px.red   = {pix[14:10], 3'b000};
        px.alpha = ALPHA_OPAQUE;
      end
      default: begin
        px.blue  = pix[7:0];
        px.green = pix[15:8];
        px.red   = pix[23:16];
        px.alpha = (mode_q == MODE_RGBA32) ? pix[31:24] : ALPHA_OPAQUE;
      end
    endcase
    px.index   = base_q + IndexW'(col_q);
    px.is_last = 1'b0;
    byte_pos_q = 0;
    partial_q  = '0;
    if (col_q + 1 >= w) begin
      col_q = 0;
      pad_q = (4 - (w * bpp) % 4) % 4;
      if (row_q + 1 >= h) begin
        px.is_last = 1'b1;
        row_q      = 0;
        base_q     = IndexW'((h - 1) * w);
      end else begin
        row_q++;
        base_q = base_q - IndexW'(w);
      end
    end else begin
      col_q++;
    end
    expected_pixels.push_back(px);
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(value);
  endtask

  task automatic send_bytes(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                           input logic [1:0] mode);
    wait_idle();
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
    cfg_write(CFG_MODE, DimW'(mode));
  endtask

  // 1x1, 24-bit after reset: pixel, one pad byte, then the next image
  task automatic test_reset_state();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_bytes(3);
  endtask

  task automatic test_pixel_modes();
    configure(13'd3, 13'd2, MODE_RGB555);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_bytes(2);
    configure(13'd2, 13'd1, MODE_RGB24);
    send_bytes(8);
    configure(13'd1, 13'd2, MODE_RGBA32);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_bytes(8);
  endtask

  // zero acts as one, above the maximum clamps
  task automatic test_dimension_limits();
    configure(13'd0, 13'd0, MODE_RGB24);
    send_bytes(4);
    configure(13'd4096, 13'd4096, MODE_RGB24);
    send_bytes(4);
    configure(13'h1FFF, 13'd4097, MODE_RGB24);
    send_bytes(4);
  endtask

  // spare index keeps position, real write restarts mid-pixel
  task automatic test_register_writes();
    configure(13'd4, 13'd3, MODE_RGBA32);
    send_bytes(2);
    wait_idle();
    cfg_write(CFG_SPARE, 13'($urandom));
    send_bytes(4);
    wait_idle();
    cfg_write(CFG_WIDTH, 13'd5);
    send_bytes(4);
  endtask

  // palette load interrupted by another mode, then resumed
  task automatic test_palette();
    configure(13'd3, 13'd2, MODE_PAL8);
    send_bytes(600);
    configure(13'd2, 13'd1, MODE_RGB24);
    send_bytes(3);
    configure(13'd3, 13'd2, MODE_PAL8);
    send_bytes(424);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_bytes(10);
  endtask

  task automatic test_backpressure();
    configure(13'd7, 13'd3, MODE_PAL8);
    @(posedge clk_i);
    rx_hold = 120;
    no_idle = 1'b1;
    send_bytes(40);
    no_idle = 1'b0;
    wait_idle();
    send_bytes(16);
  endtask

  task automatic test_random_images();
    int sent;
    int n;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(19) == 0) begin
        w = 13'($urandom_range(8191, 4096));
        h = 13'($urandom_range(8191, 0));
      end else begin
        w = 13'($urandom_range(9, 0));
        h = 13'($urandom_range(4, 0));
      end
      no_idle = ($urandom_range(7) == 0);
      if ($urandom_range(4) != 0) configure(w, h, 2'($urandom));
      if ($urandom_range(9) == 0) begin
        wait_idle();
        cfg_write(CFG_SPARE, 13'($urandom));
      end
      n = $urandom_range(80, 10);
      send_bytes(n);
      sent += n;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i  = '0;
    width_q     = 13'd1;
    height_q    = 13'd1;
    mode_q      = MODE_RGB24;
    fill_q      = '0;
    loaded_q    = 1'b0;
    restart_image();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_pixel_modes();
    test_dimension_limits();
    test_register_writes();
    test_palette();
    test_backpressure();
    test_random_images();
    wait_idle();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // pixel receiver; rx_hold forces one long hold-off
  initial begin
    int stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ready_i <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_pixel
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with none expected: index %0d", pixel_index_o);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", 32'(want.red), 32'(red_o));
        check_field("green", 32'(want.green), 32'(green_o));
        check_field("blue", 32'(want.blue), 32'(blue_o));
        check_field("alpha", 32'(want.alpha), 32'(alpha_o));
        check_field("pixel_index", 32'(want.index), 32'(pixel_index_o));
        check_field("last_pixel", 32'(want.is_last), 32'(last_pixel_o));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmpd_pkg.sv
rtl/bmpd_palette_mem.sv
rtl/bmpd_ctrl.sv
rtl/bmpd_out.sv
rtl/bmp_pixel_decoder.sv
verif/tb_top.sv
